[hw/rtl/oal_pkg.sv]
// Shared types and constants for the ordered array list unit.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.
package oal_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int SIZE_W     = 7;
  localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int GROUP_SIZE = 8;
  localparam int NGROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PADDED_W   = NGROUPS * GROUP_SIZE;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT      = 3'd0,
    OP_APPEND      = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_REMOVE_LAST = 3'd3,
    OP_SEARCH      = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Command broadcast to every cell of the row in the transfer cycle.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic                    srch;
    logic [IDX_W-1:0]        pos;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

[hw/rtl/oal_cell.sv]
// One storage cell of the row: holds one entry and its search hit.
// Depends on oal_pkg.
module oal_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [oal_pkg::IDX_W-1:0]       idx,
  input  oal_pkg::cmd_t                   cmd,
  input  logic signed [oal_pkg::VAL_W-1:0] left,
  input  logic signed [oal_pkg::VAL_W-1:0] right,
  output logic signed [oal_pkg::VAL_W-1:0] entry,
  output logic                            match
);

  // Take the new value at the insert point, the left neighbour above it,
  // the right neighbour at and above a removal point.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx == cmd.pos) begin
        entry <= cmd.value;
      end else if (idx > cmd.pos) begin
        entry <= left;
      end
    end else if (cmd.rem && (idx >= cmd.pos)) begin
      entry <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else begin
      match <= cmd.srch && (oal_pkg::CNT_W'(idx) < cmd.count) && (entry == cmd.value);
    end
  end

endmodule

[hw/rtl/oal_match_tree.sv]
// First level of the search reduction: registered OR over groups of cell hits.
// Depends on oal_pkg.
module oal_match_tree (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [oal_pkg::CAPACITY-1:0]  hits,
  output logic [oal_pkg::NGROUPS-1:0]   group_hit
);

  logic [oal_pkg::PADDED_W-1:0] padded;

  assign padded = oal_pkg::PADDED_W'(hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_hit <= '0;
    end else begin
      for (int g = 0; g < oal_pkg::NGROUPS; g++) begin
        group_hit[g] <= |padded[g*oal_pkg::GROUP_SIZE +: oal_pkg::GROUP_SIZE];
      end
    end
  end

endmodule

[hw/rtl/oal_ctrl.sv]
// Operation decode and entry count: checks each operation, builds the row command.
// Depends on oal_pkg.
module oal_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [oal_pkg::OP_W-1:0]        op,
  input  logic [oal_pkg::POS_W-1:0]       position,
  input  logic signed [oal_pkg::VAL_W-1:0] value,
  output oal_pkg::cmd_t                   cmd,
  output oal_pkg::status_t                status,
  output logic [oal_pkg::CNT_W-1:0]       count_next
);

  logic [oal_pkg::CNT_W-1:0] count;
  logic [oal_pkg::CMP_W-1:0] pos_x;
  logic [oal_pkg::CMP_W-1:0] cnt_x;
  logic                      full;
  logic                      empty;
  logic                      ins;
  logic                      rem;
  logic                      srch;
  logic [oal_pkg::IDX_W-1:0] pos;

  assign pos_x = oal_pkg::CMP_W'(position);
  assign cnt_x = oal_pkg::CMP_W'(count);
  assign full  = (count == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    ins        = 1'b0;
    rem        = 1'b0;
    srch       = 1'b0;
    pos        = '0;
    status     = oal_pkg::ST_OK;
    count_next = count;
    case (op)
      oal_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = oal_pkg::ST_BAD_INDEX;
        end else if (full) begin
          status = oal_pkg::ST_FULL;
        end else begin
          ins        = 1'b1;
          pos        = oal_pkg::IDX_W'(position);
          count_next = count + oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::OP_APPEND: begin
        if (full) begin
          status = oal_pkg::ST_FULL;
        end else begin
          ins        = 1'b1;
          pos        = oal_pkg::IDX_W'(count);
          count_next = count + oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::OP_REMOVE: begin
        if (empty) begin
          status = oal_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = oal_pkg::ST_BAD_INDEX;
        end else begin
          rem        = 1'b1;
          pos        = oal_pkg::IDX_W'(position);
          count_next = count - oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::OP_REMOVE_LAST: begin
        if (empty) begin
          status = oal_pkg::ST_EMPTY;
        end else begin
          count_next = count - oal_pkg::CNT_W'(1);
        end
      end
      oal_pkg::OP_SEARCH: begin
        srch = 1'b1;
      end
      oal_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd.ins   = accept && ins;
    cmd.rem   = accept && rem;
    cmd.srch  = accept && srch;
    cmd.pos   = pos;
    cmd.count = count;
    cmd.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

[hw/rtl/ordered_array_list_unit.sv]
// Ordered array list unit: top level with the row of cells and result pipeline.
// Depends on oal_pkg, oal_ctrl, oal_cell and oal_match_tree.
//
// Use:
//   Present op, position and value with start high. The unit takes the
//   transfer at a rising edge where start is high and busy is low.
//   Each transfer gives exactly one result: status, found and size show for a
//   single cycle marked by strobe. The receiver cannot hold results off, so
//   sample them in that cycle.
// Pipeline and throughput:
//   After the transfer edge the result passes through the v1 and v2 stages and
//   then the strobe register; it is taken at the edge that ends the strobe cycle.
//   busy is high while v1 or v2 is set, so a new item is not taken before the
//   last one has left v2, and the next transfer may land in the strobe cycle.
//   The pipeline depth is set by the search path: every cell compares its entry
//   in the transfer cycle, the hits are ORed in groups of eight, then the
//   group flags are ORed into found. Inserts and removals shift the whole row
//   of cells in the transfer cycle itself; their results follow the same pipeline.
// Reset:
//   rst (synchronous, active high) empties the list and clears the pipeline.
//   Entry contents are not cleared; only entries below the size are read.
module ordered_array_list_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [oal_pkg::OP_W-1:0]        op,
  input  logic [oal_pkg::POS_W-1:0]       position,
  input  logic signed [oal_pkg::VAL_W-1:0] value,
  output logic                            strobe,
  output logic [1:0]                      status,
  output logic                            found,
  output logic [oal_pkg::SIZE_W-1:0]      size
);

  logic                            accept;
  oal_pkg::cmd_t                   cmd;
  oal_pkg::status_t                status_now;
  logic [oal_pkg::CNT_W-1:0]       count_next;
  logic signed [oal_pkg::VAL_W-1:0] entries [oal_pkg::CAPACITY];
  logic [oal_pkg::CAPACITY-1:0]    hits;
  logic [oal_pkg::NGROUPS-1:0]     group_hit;

  // Pipeline stage flags and the result fields travelling with them.
  logic                            v1;
  logic                            v2;
  oal_pkg::status_t                status1;
  oal_pkg::status_t                status2;
  logic [oal_pkg::SIZE_W-1:0]      size1;
  logic [oal_pkg::SIZE_W-1:0]      size2;

  assign busy   = v1 || v2;
  assign accept = start && !busy;

  oal_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .position   (position),
    .value      (value),
    .cmd        (cmd),
    .status     (status_now),
    .count_next (count_next)
  );

  // Row of cells: each takes from its left neighbour on insert and from its
  // right neighbour on removal. The ends tie back to something harmless.
  for (genvar i = 0; i < oal_pkg::CAPACITY; i++) begin : g_cell
    logic signed [oal_pkg::VAL_W-1:0] left_in;
    logic signed [oal_pkg::VAL_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = cmd.value;
    end else begin : g_mid_l
      assign left_in = entries[i-1];
    end

    if (i == oal_pkg::CAPACITY - 1) begin : g_last
      assign right_in = entries[i];
    end else begin : g_mid_r
      assign right_in = entries[i+1];
    end

    oal_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (oal_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .entry (entries[i]),
      .match (hits[i])
    );
  end

  oal_match_tree u_tree (
    .clk       (clk),
    .rst       (rst),
    .hits      (hits),
    .group_hit (group_hit)
  );

  // Advance the control flags; found is only ever set on a search since the
  // cells hold their hit low otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1     <= accept;
      v2     <= v1;
      strobe <= v2;
    end
  end

  // Result fields carry no reset; strobe marks when they mean something.
  always_ff @(posedge clk) begin
    if (accept) begin
      status1 <= status_now;
      size1   <= oal_pkg::SIZE_W'(count_next);
    end
    if (v1) begin
      status2 <= status1;
      size2   <= size1;
    end
    if (v2) begin
      status <= status2;
      size   <= size2;
      found  <= |group_hit;
    end
  end

endmodule

[bench/tb_ordered_array_list_unit.sv]
// Self-checking testbench for ordered_array_list_unit: directed, full-store and random sequences.
// Depends on oal_pkg and the ordered_array_list_unit RTL; needs no other file.
`timescale 1ns / 1ps

module tb_ordered_array_list_unit;
  import oal_pkg::*;

  // Cycles to wait after the last expected result before declaring the unit idle.
  localparam int SETTLE_CYCLES = 6;
  // Upper bound on cycles spent waiting for outstanding results in one drain.
  localparam int DRAIN_LIMIT   = 100;

  typedef struct packed {
    status_t           status;
    logic              found;
    logic [SIZE_W-1:0] size;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;
  logic                     strobe;
  logic [1:0]               status;
  logic                     found;
  logic [SIZE_W-1:0]        size;

  // Shadow copy of the list, updated at every transfer.
  logic signed [VAL_W-1:0]  shadow_entries [CAPACITY];
  int                       shadow_count;

  // Results predicted for accepted transfers, oldest first.
  list_result_t             pending_results [$];
  int                       mismatch_count;
  bit                       gaps_enabled;

  ordered_array_list_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .position (position),
    .value    (value),
    .strobe   (strobe),
    .status   (status),
    .found    (found),
    .size     (size)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return the result it should give.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] code,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           idx;
    res.status = ST_OK;
    res.found  = 1'b0;
    idx        = int'(pos);
    case (code)
      OP_INSERT: begin
        // An index past the end is refused before fullness is considered.
        if (idx > shadow_count) begin
          res.status = ST_BAD_INDEX;
        end else if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = val;
          shadow_count++;
        end
      end
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        // An empty list wins over a bad index.
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (idx >= shadow_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      OP_REMOVE_LAST: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else shadow_count--;
      end
      OP_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] == val) res.found = 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        // Unused codes leave the list alone and report ok.
      end
    endcase
    res.size = shadow_count[SIZE_W-1:0];
    return res;
  endfunction

  // Check each result in its strobe cycle, then record the transfer taken at this edge.
  // Checking comes first so that a result and a transfer on the same edge stay in order.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst) begin
      if (strobe) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0d found %0d size %0d",
                 status, found, size);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_count++;
          end
          if (size !== want.size) begin
            $error("size: expected %0d, got %0d", want.size, size);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(apply_list_op(op, position, value));
    end
  end

  // Present one item and hold it until the transfer edge; optionally idle first.
  task automatic send_item(input logic [OP_W-1:0] code, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= code;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every expected result has arrived, then let the unit settle.
  task automatic drain_results();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly random words, with the extremes, zero and the all-ones pattern mixed in.
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Search key: often a value already held, so that hits are common.
  function automatic logic signed [VAL_W-1:0] search_key();
    if (shadow_count > 0 && $urandom_range(0, 1) == 1)
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    return rand_value();
  endfunction

  // Boundary cases on a short list: empty removes, bad indexes, ends, unused codes.
  task automatic test_directed();
    send_item(OP_SEARCH,      7'd0,   32'sd0);
    send_item(OP_REMOVE_LAST, 7'd0,   32'sd0);
    send_item(OP_REMOVE,      7'd127, 32'sd0);
    send_item(OP_REMOVE,      7'd0,   32'sd0);
    send_item(OP_INSERT,      7'd1,   32'sd9);
    send_item(OP_INSERT,      7'd0,   {1'b1, 31'd0});
    send_item(OP_APPEND,      7'd0,   {1'b0, {31{1'b1}}});
    send_item(OP_INSERT,      7'd2,   '1);
    send_item(OP_INSERT,      7'd1,   32'sd0);
    send_item(OP_INSERT,      7'd64,  32'sd5);
    send_item(OP_INSERT,      7'd127, 32'sd5);
    send_item(OP_SEARCH,      7'd0,   {1'b0, {31{1'b1}}});
    send_item(OP_SEARCH,      7'd127, 32'sd1);
    send_item(OP_SEARCH,      7'd0,   {1'b1, 31'd0});
    send_item(OP_REMOVE,      7'd4,   32'sd0);
    send_item(OP_REMOVE,      7'd127, 32'sd0);
    send_item(OP_REMOVE,      7'd0,   32'sd0);
    send_item(OP_REMOVE,      7'd1,   32'sd0);
    send_item(OP_REMOVE_LAST, 7'd0,   32'sd0);
    send_item(3'd6,           7'd127, '1);
    send_item(3'd7,           7'd0,   32'sd0);
    send_item(OP_SEARCH,      7'd0,   32'sd0);
    send_item(OP_CLEAR,       7'd0,   32'sd0);
    send_item(OP_SEARCH,      7'd0,   32'sd0);
    send_item(OP_REMOVE_LAST, 7'd0,   32'sd0);
  endtask

  // Fill the store, then push on every refusal and edit both ends while full.
  task automatic test_full_store();
    send_item(OP_CLEAR, 7'd0, 32'sd0);
    for (int i = 0; i < CAPACITY; i++) send_item(OP_APPEND, 7'($urandom_range(0, 127)), rand_value());
    send_item(OP_APPEND,      7'd0,  32'sd3);
    send_item(OP_INSERT,      7'd0,  32'sd3);
    send_item(OP_INSERT,      7'd64, 32'sd3);
    send_item(OP_INSERT,      7'd65, 32'sd3);
    send_item(OP_SEARCH,      7'd0,  shadow_entries[CAPACITY-1]);
    send_item(OP_SEARCH,      7'd0,  shadow_entries[0]);
    send_item(OP_REMOVE,      7'd64, 32'sd0);
    send_item(OP_REMOVE,      7'd63, 32'sd0);
    send_item(OP_INSERT,      7'd63, rand_value());
    send_item(OP_REMOVE,      7'd0,  32'sd0);
    send_item(OP_INSERT,      7'd0,  rand_value());
    send_item(OP_REMOVE_LAST, 7'd0,  32'sd0);
    send_item(OP_APPEND,      7'd0,  rand_value());
  endtask

  // Random traffic; grow_pct steers the size up (towards full) or down (towards empty).
  task automatic test_random(input int items, input int grow_pct);
    int               sel;
    logic [OP_W-1:0]  code;
    logic [POS_W-1:0] pos;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      pos = 7'($urandom_range(0, 127));
      if (sel < 1 && grow_pct < 50) begin
        code = OP_CLEAR;
      end else if (sel < 3) begin
        code = 3'($urandom_range(6, 7));
      end else if (sel < 3 + grow_pct) begin
        code = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_APPEND;
        if ($urandom_range(0, 99) < 85) pos = 7'($urandom_range(0, shadow_count));
      end else if (sel < 23 + grow_pct) begin
        code = OP_SEARCH;
      end else begin
        code = ($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_REMOVE_LAST;
        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
          pos = 7'($urandom_range(0, shadow_count - 1));
      end
      send_item(code, pos, (code == OP_SEARCH) ? search_key() : rand_value());
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_SEARCH;
    position       = '0;
    value          = '0;
    shadow_count   = 0;
    mismatch_count = 0;
    gaps_enabled   = 1'b1;
    for (int i = 0; i < CAPACITY; i++) shadow_entries[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_store();
    // Pause the sender here until every outstanding result is in.
    drain_results();
    test_random(480, 60);
    test_random(400, 35);
    drain_results();
    // Final stretch back to back, with no idling at all.
    gaps_enabled = 1'b0;
    test_random(320, 48);
    drain_results();

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
